// ===== rtl/pds_pkg.sv =====
// Shared types and constants for the periodic deadline scheduler.
`timescale 1ns / 1ps

package pds_pkg;

  localparam int unsigned COMP_W      = 8;
  localparam int unsigned DEST_W      = 16;
  localparam int unsigned PER_W       = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_NOP      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_FULL       = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FIRED      = 3'd4,
    ST_NOTHING    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [COMP_W-1:0] comp;
    logic [DEST_W-1:0] dest;
    logic [PER_W-1:0]  per;
    logic [TIME_W-1:0] due;
  } row_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic commit;
    logic flush;
  } pds_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic tick_pick;
    logic pick_limit;
  } pds_sts_t;

endpackage

// ===== rtl/pds_ctrl.sv =====
// Sequencing state machine of the periodic deadline scheduler.
`timescale 1ns / 1ps

module pds_ctrl import pds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  kind_i,
  input  pds_sts_t    sts_i,
  output logic        in_ready_o,
  output pds_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (kind_e'(kind_i) != KIND_NOP)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.tick_pick) begin
            state_d = sts_i.pick_limit ? S_FLUSH : S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit    = sts_i.out_free;
        // Another pass looks for the next due entry after this one.
        cmd_o.scan_init = sts_i.out_free && sts_i.tick_pick && !sts_i.pick_limit;
      end
      S_FLUSH: begin
        cmd_o.flush = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/pds_datapath.sv =====
// Slot table, time counter, scan compare stage and result register.
`timescale 1ns / 1ps

module pds_datapath import pds_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pds_cmd_t          cmd_i,
  input  logic [1:0]        kind_i,
  input  logic [COMP_W-1:0] component_i,
  input  logic [DEST_W-1:0] destination_i,
  input  logic [PER_W-1:0]  period_i,
  input  logic              out_ready_i,
  output pds_sts_t          sts_o,
  output logic              out_valid_o,
  output logic [2:0]        status_o,
  output logic [COMP_W-1:0] fired_component_o,
  output logic [DEST_W-1:0] fired_destination_o,
  output logic              last_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SCAN_W = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W  = COMP_W + DEST_W + IDX_W;
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(ENTRIES);

  // Control state.
  kind_e              op_q;
  logic [TIME_W-1:0]  now_q;
  logic [ENTRIES-1:0] valid_q;
  logic [SCAN_W-1:0]  scan_idx_q;
  logic               rd_vld_q;
  logic               best_found_q;
  logic               prev_found_q;
  logic [CNT_W-1:0]   fire_cnt_q;
  logic               pend_vld_q;
  logic               out_valid_q;

  // Payload state.
  logic [COMP_W-1:0]  req_comp_q;
  logic [DEST_W-1:0]  req_dest_q;
  logic [PER_W-1:0]   req_per_q;
  row_t               slot_mem_q [ENTRIES];
  logic [IDX_W-1:0]   rd_idx_q;
  row_t               rd_row_q;
  logic [IDX_W-1:0]   best_idx_q;
  row_t               best_row_q;
  logic [TIME_W-1:0]  best_dist_q;
  logic [KEY_W-1:0]   prev_key_q;
  logic [COMP_W-1:0]  pend_comp_q;
  logic [DEST_W-1:0]  pend_dest_q;
  status_e            out_status_q;
  logic [COMP_W-1:0]  out_comp_q;
  logic [DEST_W-1:0]  out_dest_q;
  logic               out_last_q;

  logic               issue;
  logic [IDX_W-1:0]   rd_addr;
  logic               cand_valid;
  logic [KEY_W-1:0]   cand_key;
  logic [KEY_W-1:0]   best_key;
  logic [TIME_W-1:0]  cand_dist;
  logic [TIME_W-1:0]  elapsed;
  logic               take;
  logic               mem_we;
  row_t               mem_wdata;
  logic               emit;
  status_e            emit_status;
  logic [COMP_W-1:0]  emit_comp;
  logic [DEST_W-1:0]  emit_dest;
  logic               emit_last;

  assign issue      = cmd_i.scan_run && (scan_idx_q < SCAN_END);
  assign rd_addr    = scan_idx_q[IDX_W-1:0];
  assign cand_valid = valid_q[rd_idx_q];
  assign cand_key   = {rd_row_q.comp, rd_row_q.dest, rd_idx_q};
  assign best_key   = {best_row_q.comp, best_row_q.dest, best_idx_q};
  assign cand_dist  = rd_row_q.due - now_q;
  assign elapsed    = now_q - rd_row_q.due;

  // Compare stage: decides whether the slot just read replaces the best so far.
  always_comb begin
    take = 1'b0;
    case (op_q)
      KIND_REGISTER: begin
        take = !cand_valid && !best_found_q;
      end
      KIND_REMOVE: begin
        take = cand_valid && (rd_row_q.comp == req_comp_q) &&
               (rd_row_q.dest == req_dest_q) &&
               (!best_found_q || (cand_dist < best_dist_q));
      end
      KIND_TICK: begin
        // Due entries are picked in key order, one per pass, each after the last pick.
        take = cand_valid && !elapsed[TIME_W-1] &&
               (!prev_found_q || (cand_key > prev_key_q)) &&
               (!best_found_q || (cand_key < best_key));
      end
      default: take = 1'b0;
    endcase
    take = take && rd_vld_q && cmd_i.scan_run;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = best_row_q;
    if (cmd_i.commit && best_found_q) begin
      if (op_q == KIND_REGISTER) begin
        mem_we         = 1'b1;
        mem_wdata.comp = req_comp_q;
        mem_wdata.dest = req_dest_q;
        mem_wdata.per  = req_per_q;
        mem_wdata.due  = now_q + TIME_W'(req_per_q);
      end else if (op_q == KIND_TICK) begin
        mem_we        = 1'b1;
        mem_wdata.due = best_row_q.due + TIME_W'(best_row_q.per);
      end
    end
  end

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_NOTHING;
    emit_comp   = req_comp_q;
    emit_dest   = req_dest_q;
    emit_last   = 1'b1;
    if (cmd_i.flush) begin
      emit        = 1'b1;
      emit_status = ST_FIRED;
      emit_comp   = pend_comp_q;
      emit_dest   = pend_dest_q;
    end else if (cmd_i.commit) begin
      case (op_q)
        KIND_REGISTER: begin
          emit        = 1'b1;
          emit_status = best_found_q ? ST_REGISTERED : ST_FULL;
        end
        KIND_REMOVE: begin
          emit        = 1'b1;
          emit_status = best_found_q ? ST_REMOVED : ST_NOT_FOUND;
        end
        KIND_TICK: begin
          // A fired entry leaves only once it is known whether another follows.
          emit        = pend_vld_q;
          emit_status = ST_FIRED;
          emit_comp   = pend_comp_q;
          emit_dest   = pend_dest_q;
          emit_last   = !best_found_q;
          if (!pend_vld_q && !best_found_q) begin
            emit        = 1'b1;
            emit_status = ST_NOTHING;
            emit_comp   = '0;
            emit_dest   = '0;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= KIND_NOP;
      now_q        <= '0;
      valid_q      <= '0;
      scan_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      prev_found_q <= 1'b0;
      fire_cnt_q   <= '0;
      pend_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q         <= kind_e'(kind_i);
        fire_cnt_q   <= '0;
        prev_found_q <= 1'b0;
        pend_vld_q   <= 1'b0;
        if (kind_e'(kind_i) == KIND_TICK) begin
          now_q <= now_q + 1'b1;
        end
      end
      if (cmd_i.load || cmd_i.scan_init) begin
        scan_idx_q   <= '0;
        rd_vld_q     <= 1'b0;
        best_found_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (take) begin
          best_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit && best_found_q) begin
        case (op_q)
          KIND_REGISTER: valid_q[best_idx_q] <= 1'b1;
          KIND_REMOVE:   valid_q[best_idx_q] <= 1'b0;
          KIND_TICK: begin
            fire_cnt_q   <= fire_cnt_q + 1'b1;
            prev_found_q <= 1'b1;
            pend_vld_q   <= 1'b1;
          end
          default: pend_vld_q <= pend_vld_q;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_comp_q <= component_i;
      req_dest_q <= destination_i;
      req_per_q  <= (period_i == '0) ? PER_W'(1) : period_i;
    end
    if (issue) begin
      rd_idx_q <= rd_addr;
      rd_row_q <= slot_mem_q[rd_addr];
    end
    if (mem_we) begin
      slot_mem_q[best_idx_q] <= mem_wdata;
    end
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_row_q  <= rd_row_q;
      best_dist_q <= cand_dist;
    end
    if (cmd_i.commit && best_found_q && (op_q == KIND_TICK)) begin
      prev_key_q  <= best_key;
      pend_comp_q <= best_row_q.comp;
      pend_dest_q <= best_row_q.dest;
    end
    if (emit) begin
      out_status_q <= emit_status;
      out_comp_q   <= emit_comp;
      out_dest_q   <= emit_dest;
      out_last_q   <= emit_last;
    end
  end

  assign sts_o.scan_done  = (scan_idx_q == SCAN_END) && !rd_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.tick_pick  = (op_q == KIND_TICK) && best_found_q;
  assign sts_o.pick_limit = (fire_cnt_q == CNT_W'(MAX_RESULTS - 1));

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign fired_component_o   = out_comp_q;
  assign fired_destination_o = out_dest_q;
  assign last_o              = out_last_q;

endmodule

// ===== rtl/periodic_deadline_scheduler_core.sv =====
// Top level of the periodic deadline scheduler.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | input     | in_valid_i/in_ready_o | kind_i, component_i, destination_i,
//           |           |                       | period_i
//   out     | output    | out_valid_o/          | status_o, fired_component_o,
//           |           | out_ready_i           | fired_destination_o, last_o
//
// Register and remove items make one pass over the slot memory through its single
// registered read port, then one commit step.
// A tick makes one pass and one commit per fired entry, since each pass finds the next
// due entry in order, and then a final pass that finds none; when MAX_RESULTS entries
// fire, a flush step takes the place of that final pass.
// Reset clears the valid bits and the time counter at once; no clearing pass.
// A stalled output holds the commit until the result register frees; the next
// item is taken while the final result of the previous one still waits.
`timescale 1ns / 1ps

module periodic_deadline_scheduler_core import pds_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [COMP_W-1:0] component_i,
  input  logic [DEST_W-1:0] destination_i,
  input  logic [PER_W-1:0]  period_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [COMP_W-1:0] fired_component_o,
  output logic [DEST_W-1:0] fired_destination_o,
  output logic              last_o
);

  pds_cmd_t cmd;
  pds_sts_t sts;

  pds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  pds_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .kind_i              (kind_i),
    .component_i         (component_i),
    .destination_i       (destination_i),
    .period_i            (period_i),
    .out_ready_i         (out_ready_i),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .status_o            (status_o),
    .fired_component_o   (fired_component_o),
    .fired_destination_o (fired_destination_o),
    .last_o              (last_o)
  );

endmodule
